FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the beam-search top-k block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bsts_pkg.sv
// Shared constants, types and helpers of the beam-search top-k block.
package bsts_pkg;

  // Port field widths
  localparam int SCORE_FW = 32;
  localparam int TOKEN_FW = 24;
  localparam int IDX_W    = 6;
  localparam int PARENT_W = 3;
  localparam int IN_DW    = 88;
  localparam int OUT_DW   = 72;

  // Configuration register
  localparam int CFG_W            = 4;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;
  localparam logic [CFG_W-1:0] BEAM_WIDTH_RESET = 4'd4;
  localparam logic REG_BEAM_WIDTH = 1'b0;

  // Parameter defaults
  localparam int MAX_BEAM_DEF   = 8;
  localparam int SCORE_BITS_DEF = 32;
  localparam int TOKEN_BITS_DEF = 24;

  // Per-cell control
  typedef struct packed {
    logic ins;         // sorted insert of the broadcast entry
    logic wr_sel;      // direct write of the broadcast entry
    logic shift_down;  // take the upper neighbor during drain
    logic clear;       // end of group
    logic in_range;    // cell lies below the current width
    logic upper_ok;    // upper neighbor lies below the current width
  } cell_ctrl_t;

  // Parent beam = idx / w for w in 1..8 and idx < 8*w, by scaled reciprocal
  function automatic logic [PARENT_W-1:0] parent_of(logic [IDX_W-1:0] idx,
                                                    logic [CFG_W-1:0] w);
    logic [10:0] recip;
    logic [16:0] prod;
    unique case (w)
      4'd2:    recip = 11'd512;
      4'd3:    recip = 11'd342;
      4'd4:    recip = 11'd256;
      4'd5:    recip = 11'd205;
      4'd6:    recip = 11'd171;
      4'd7:    recip = 11'd147;
      4'd8:    recip = 11'd128;
      default: recip = 11'd1024;
    endcase
    prod = 17'(idx) * 17'(recip);
    return prod[10 +: PARENT_W];
  endfunction

endpackage

FILE: src/bsts_cell.sv
// One slot of the sorted insertion chain: holds one kept candidate.
module bsts_cell
  import bsts_pkg::*;
#(
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cell_ctrl_t                   ctrl,
  // broadcast candidate
  input  logic signed [SCORE_BITS-1:0] new_score,
  input  logic        [TOKEN_BITS-1:0] new_token,
  input  logic        [IDX_W-1:0]      new_index,
  // lower neighbor (better rank)
  input  logic                         prev_hit,
  input  logic signed [SCORE_BITS-1:0] lo_score,
  input  logic        [TOKEN_BITS-1:0] lo_token,
  input  logic        [IDX_W-1:0]      lo_index,
  input  logic                         lo_valid,
  // upper neighbor (worse rank)
  input  logic signed [SCORE_BITS-1:0] up_score,
  input  logic        [TOKEN_BITS-1:0] up_token,
  input  logic        [IDX_W-1:0]      up_index,
  input  logic                         up_valid,
  // contents and compare result
  output logic                         hit,
  output logic signed [SCORE_BITS-1:0] q_score,
  output logic        [TOKEN_BITS-1:0] q_token,
  output logic        [IDX_W-1:0]      q_index,
  output logic                         q_valid
);

  logic signed [SCORE_BITS-1:0] score_r;
  logic        [TOKEN_BITS-1:0] token_r;
  logic        [IDX_W-1:0]      index_r;
  logic                         valid_r;
  logic                         own_hit;
  logic                         take_new;
  logic                         take_lo;

  // New entry beats this slot; ties stay with the older entry
  assign own_hit  = ctrl.ins && ctrl.in_range && (!valid_r || (new_score > score_r));
  // Carry the insert point upward: every in-range slot above the first hit shifts
  assign hit      = prev_hit || own_hit;
  assign take_new = ctrl.wr_sel || (own_hit && !prev_hit);
  assign take_lo  = ctrl.ins && ctrl.in_range && prev_hit;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      priority if (ctrl.clear) begin
        valid_r <= 1'b0;
      end else if (ctrl.shift_down) begin
        valid_r <= up_valid && ctrl.upper_ok;
      end else if (take_new) begin
        valid_r <= 1'b1;
      end else if (take_lo) begin
        valid_r <= lo_valid;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    priority if (ctrl.shift_down) begin
      score_r <= up_score;
      token_r <= up_token;
      index_r <= up_index;
    end else if (take_new) begin
      score_r <= new_score;
      token_r <= new_token;
      index_r <= new_index;
    end else if (take_lo) begin
      score_r <= lo_score;
      token_r <= lo_token;
      index_r <= lo_index;
    end
  end

  assign q_score = score_r;
  assign q_token = token_r;
  assign q_index = index_r;
  assign q_valid = valid_r;

endmodule

FILE: src/beam_search_topk_step_core.sv
// Top level of the beam-search top-k step: counters, cell chain, drain and output register.
//
// Usage: candidates of one request group stream in on in_* beam-major, one
// item per cycle while in_tready is high (source beam score and candidate
// score in Q16.16, token); in_tuser carries the first-step flag and in_tlast
// marks the final candidate. Outside first-step mode each candidate is
// compared against every slot of the kept chain at once and takes its place,
// so input runs at one item per cycle. After the final candidate the input
// stalls while the chain drains: slot 0 moves to the output register and the
// chain shifts down one slot per cycle while that register is free, giving
// one result per cycle (best first outside first-step mode, out_tlast on the
// last one). The first result is loaded in the drain state once the output
// register is free; a stalled output register holds the chain, and the drain
// ends with no result when nothing was kept. The next group may start while
// the last result still waits. Reset clears the kept slots, counters and
// output valid and sets the width register to 4. The width register must be
// written over the APB port between items only; the block does not check it.
`include "assert_macros.svh"

module beam_search_topk_step_core
  import bsts_pkg::*;
#(
  parameter int MAX_BEAM   = MAX_BEAM_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // candidate input
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // source_score[31:0], cand_score[63:32], token_in[87:64]
  input  logic              in_tuser,   // first_step
  input  logic              in_tlast,   // last_candidate
  // result output
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // new_score[31:0], token_out[55:32],
                                        // flat_index[61:56], origin_beam[64:62], zero pad
  output logic              out_tlast,  // last_result
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_DRAIN  = 1'b1;

  logic              state_r, state_nxt;
  logic [CFG_W-1:0]  width_r;
  logic [CFG_W-1:0]  eff_w;
  logic [CNT_W-1:0]  beam_r, pos_r;
  logic              full_r;
  logic              gfirst_r;
  logic              out_tvalid_r;
  logic [OUT_DW-1:0] out_tdata_r;
  logic              out_tlast_r;

  logic                         in_acc;
  logic                         starting;
  logic                         gmode;
  logic                         do_keep;
  logic [CFG_W-1:0]             beam_w, pos_w, pos_inc, beam_inc;
  logic [IDX_W:0]               flat_full;
  logic [IDX_W-1:0]             flat_idx;
  logic signed [SCORE_BITS-1:0] src_s, cand_s, new_s;
  logic signed [SCORE_BITS:0]   sum_s;
  logic [TOKEN_BITS-1:0]        tok_in;
  logic                         drain_ld, is_last, drain_end;

  logic signed [SCORE_BITS-1:0] c_score [MAX_BEAM];
  logic        [TOKEN_BITS-1:0] c_token [MAX_BEAM];
  logic        [IDX_W-1:0]      c_index [MAX_BEAM];
  logic        [MAX_BEAM-1:0]   c_valid;
  logic        [MAX_BEAM-1:0]   c_hit;
  logic        [MAX_BEAM-1:0]   c_upv;
  cell_ctrl_t                   c_ctrl  [MAX_BEAM];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_BEAM_WIDTH) ? APB_DW'(width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= BEAM_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_BEAM_WIDTH)) begin
      width_r <= pwdata[CFG_W-1:0];
    end
  end

  // Clamp width into 1..MAX_BEAM
  always_comb begin
    if (width_r == '0) begin
      eff_w = CFG_W'(1);
    end else if (width_r > CFG_W'(MAX_BEAM)) begin
      eff_w = CFG_W'(MAX_BEAM);
    end else begin
      eff_w = width_r;
    end
  end

  // Candidate decode and saturating add
  assign src_s  = SCORE_BITS'(in_tdata[SCORE_FW-1:0]);
  assign cand_s = SCORE_BITS'(in_tdata[2*SCORE_FW-1:SCORE_FW]);
  assign tok_in = TOKEN_BITS'(in_tdata[2*SCORE_FW+TOKEN_FW-1:2*SCORE_FW]);
  assign sum_s  = {src_s[SCORE_BITS-1], src_s} + {cand_s[SCORE_BITS-1], cand_s};

  always_comb begin
    if (sum_s[SCORE_BITS] != sum_s[SCORE_BITS-1]) begin
      new_s = sum_s[SCORE_BITS] ? {1'b1, {(SCORE_BITS-1){1'b0}}}
                                : {1'b0, {(SCORE_BITS-1){1'b1}}};
    end else begin
      new_s = sum_s[SCORE_BITS-1:0];
    end
  end

  // Group position and mode
  assign in_tready = (state_r == ST_ACCEPT);
  assign in_acc    = in_tvalid && in_tready;
  assign starting  = (beam_r == '0) && (pos_r == '0) && !full_r;
  assign gmode     = starting ? in_tuser : gfirst_r;
  assign beam_w    = CFG_W'(beam_r);
  assign pos_w     = CFG_W'(pos_r);
  assign pos_inc   = pos_w + CFG_W'(1);
  assign beam_inc  = beam_w + CFG_W'(1);
  assign do_keep   = in_acc && !full_r && (beam_w < eff_w) && (pos_w < eff_w);
  assign flat_full = (IDX_W+1)'(beam_w) * (IDX_W+1)'(eff_w) + (IDX_W+1)'(pos_w);
  assign flat_idx  = flat_full[IDX_W-1:0];

  // Drain control
  assign drain_ld  = (state_r == ST_DRAIN) && c_valid[0] && (!out_tvalid_r || out_tready);
  assign is_last   = !c_upv[0];
  assign drain_end = (state_r == ST_DRAIN) && (!c_valid[0] || (drain_ld && is_last));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCEPT: if (in_acc && in_tlast) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (drain_end) state_nxt = ST_ACCEPT;
      default:   state_nxt = ST_ACCEPT;
    endcase
  end

  // Counters and group mode; advance per accepted item until full, clear at group end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ACCEPT;
      beam_r   <= '0;
      pos_r    <= '0;
      full_r   <= 1'b0;
      gfirst_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (drain_end) begin
        beam_r   <= '0;
        pos_r    <= '0;
        full_r   <= 1'b0;
        gfirst_r <= 1'b0;
      end else if (in_acc) begin
        if (starting) gfirst_r <= in_tuser;
        if (!full_r) begin
          if (pos_inc >= eff_w) begin
            pos_r <= '0;
            if (beam_inc >= eff_w) begin
              beam_r <= '0;
              full_r <= 1'b1;
            end else begin
              beam_r <= beam_r + CNT_W'(1);
            end
          end else begin
            pos_r <= pos_r + CNT_W'(1);
          end
        end
      end
    end
  end

  // Cell chain
  for (genvar j = 0; j < MAX_BEAM; j++) begin : g_cell
    logic signed [SCORE_BITS-1:0] lo_score, up_score;
    logic        [TOKEN_BITS-1:0] lo_token, up_token;
    logic        [IDX_W-1:0]      lo_index, up_index;
    logic                         lo_valid, up_valid, lo_hit;

    if (j == 0) begin : g_lo_edge
      assign lo_score = '0;
      assign lo_token = '0;
      assign lo_index = '0;
      assign lo_valid = 1'b0;
      assign lo_hit   = 1'b0;
    end else begin : g_lo
      assign lo_score = c_score[j-1];
      assign lo_token = c_token[j-1];
      assign lo_index = c_index[j-1];
      assign lo_valid = c_valid[j-1];
      assign lo_hit   = c_hit[j-1];
    end

    if (j == MAX_BEAM-1) begin : g_up_edge
      assign up_score = '0;
      assign up_token = '0;
      assign up_index = '0;
      assign up_valid = 1'b0;
    end else begin : g_up
      assign up_score = c_score[j+1];
      assign up_token = c_token[j+1];
      assign up_index = c_index[j+1];
      assign up_valid = c_valid[j+1];
    end

    always_comb begin
      c_ctrl[j].ins        = do_keep && !gmode;
      c_ctrl[j].wr_sel     = do_keep && gmode && (beam_r == '0) && (pos_w == CFG_W'(j));
      c_ctrl[j].shift_down = drain_ld;
      c_ctrl[j].clear      = drain_end;
      c_ctrl[j].in_range   = CFG_W'(j) < eff_w;
      c_ctrl[j].upper_ok   = CFG_W'(j + 1) < eff_w;
    end

    assign c_upv[j] = up_valid && c_ctrl[j].upper_ok;

    bsts_cell #(
      .SCORE_BITS (SCORE_BITS),
      .TOKEN_BITS (TOKEN_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (c_ctrl[j]),
      .new_score (gmode ? cand_s : new_s),
      .new_token (tok_in),
      .new_index (flat_idx),
      .prev_hit  (lo_hit),
      .lo_score  (lo_score),
      .lo_token  (lo_token),
      .lo_index  (lo_index),
      .lo_valid  (lo_valid),
      .up_score  (up_score),
      .up_token  (up_token),
      .up_index  (up_index),
      .up_valid  (up_valid),
      .hit       (c_hit[j]),
      .q_score   (c_score[j]),
      .q_token   (c_token[j]),
      .q_index   (c_index[j]),
      .q_valid   (c_valid[j])
    );
  end

  // Output register; load slot 0 when free, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (drain_ld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_ld) begin
      out_tdata_r <= {(OUT_DW-SCORE_FW-TOKEN_FW-IDX_W-PARENT_W)'(0),
                      parent_of(c_index[0], eff_w),
                      c_index[0],
                      TOKEN_FW'($unsigned(c_token[0])),
                      SCORE_FW'($unsigned(c_score[0]))};
      out_tlast_r <= is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Checks
  `ASSERT_RST(a_prefix_valid, clk, rst_n,
    (state_r == ST_ACCEPT) |-> ((c_valid & (c_valid + 1'b1)) == '0),
    "kept slots are not a contiguous prefix")

  `ASSERT_RST(a_last_ends_drain, clk, rst_n,
    (drain_ld && is_last) |=> (state_r == ST_ACCEPT),
    "drain did not end after the last result")

  `ASSERT_RST(a_group_cleared, clk, rst_n,
    ((state_r == ST_ACCEPT) && ($past(state_r) == ST_DRAIN)) |->
      ((c_valid == '0) && (beam_r == '0) && (pos_r == '0) && !full_r),
    "group state not cleared after drain")

  `ASSERT_ALWAYS(a_reset_idle, clk,
    !rst_n |=> (!out_tvalid && in_tready),
    "block not idle after reset")

endmodule
